@@ hdl/soht_pkg.sv @@
// ----------------------------------------------------------------------------
// soht_pkg: shared types and constants of the slot owner hash table
// Entry layout, outcome codes, hash constants and controller/datapath links.
// ----------------------------------------------------------------------------
package soht_pkg;

  localparam int IN_W  = 344;
  localparam int OUT_W = 32;

  localparam logic [63:0] HASH_ADD   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] HASH_MUL   = 64'hff51afd7ed558ccd;
  localparam int          HASH_SHIFT = 33;
  localparam logic [63:0] SLOT_MAX   = 64'h0000_0000_0000_ffff;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef enum logic [3:0] {
    OUT_REJECTED    = 4'd0,
    OUT_INSERTED    = 4'd1,
    OUT_HIT_MATCH   = 4'd2,
    OUT_HIT_UPDATED = 4'd3,
    OUT_FULL        = 4'd4,
    OUT_MISS        = 4'd5,
    OUT_STALE       = 4'd6,
    OUT_WOULD_SKIP  = 4'd7,
    OUT_FALSE_POS   = 4'd8,
    OUT_MISMATCH    = 4'd9
  } outcome_t;

  typedef enum logic [1:0] {
    RES_REJECT = 2'd0,
    RES_PROBE  = 2'd1,
    RES_FULL   = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic        used;
    logic [63:0] blk;
    logic [63:0] base;
    logic [15:0] slot;
    logic [15:0] owner;
    logic [31:0] gen;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       div_slot;
    logic       slot_check;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       div_mod;
    logic       probe_init;
    logic       mem_rd;
    logic       probe_adv;
    logic       commit;
    res_sel_t   res_sel;
    logic       clr_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic pre_bad;
    logic div_done;
    logic slot_bad;
    logic mod_done;
    logic probe_stop;
    logic probe_last;
    logic clr_last;
  } stat_t;

endpackage

@@ hdl/soht_div.sv @@
// ----------------------------------------------------------------------------
// soht_div: serial restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module soht_div import soht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);

  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] shift;
  logic        ge;

  assign shift = {rem, quot[63]};
  assign ge    = shift >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      if (cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[62:0], ge};
      rem  <= ge ? 32'(shift - {1'b0, dsr}) : shift[31:0];
    end
  end

endmodule

@@ hdl/soht_dp.sv @@
// ----------------------------------------------------------------------------
// soht_dp: datapath of the slot owner hash table
// Request register, slot divider, hash multiplier and reduction, probe walk,
// table memory.
// ----------------------------------------------------------------------------
module soht_dp import soht_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [0:0]       s_tuser,
  output logic [OUT_W-1:0] m_tdata,
  input  cmd_t             cmd,
  output stat_t            stat
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [17:0]   MOD_N    = 18'(TABLE_ENTRIES);

  // Request fields.
  logic        op;
  logic [63:0] handle, base, addr;
  logic [31:0] bbytes, obytes, count, gen;
  logic        run_ok, eq;
  logic [15:0] owner;

  logic [15:0] slot;
  logic [63:0] x, acc;
  logic [IW-1:0] idx, cnt, clr_idx;
  logic [10:0] coll;
  entry_t      rd;

  logic [3:0]  res_outcome;
  logic        res_fb;
  logic [10:0] res_coll;
  logic [15:0] res_slot;

  // Serial divider for the slot index.
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_q;
  logic [31:0] div_dsr, div_r;
  logic [63:0] off, x0, hmix, prod;
  logic [31:0] ma, mb;

  // Hash reduction modulo TABLE_ENTRIES.
  logic [63:0] red_val;
  logic [16:0] red_rem;
  logic [3:0]  red_cnt;
  logic        red_busy, red_done;
  logic [17:0] red_step;

  assign off = addr - base;
  assign hmix = acc ^ (acc >> HASH_SHIFT);

  assign div_start = cmd.div_slot;
  assign div_dvd   = {32'd0, off[31:0]};
  assign div_dsr   = obytes;

  soht_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      handle <= s_tdata[63:0];
      base   <= s_tdata[127:64];
      bbytes <= s_tdata[159:128];
      addr   <= s_tdata[223:160];
      obytes <= s_tdata[255:224];
      count  <= s_tdata[287:256];
      run_ok <= s_tdata[288];
      owner  <= s_tdata[304:289];
      gen    <= s_tdata[336:305];
      eq     <= s_tdata[337];
      op     <= s_tuser[0];
    end
  end

  assign stat.pre_bad = (handle == 64'd0) || (base == 64'd0) || (addr == 64'd0) ||
                        (obytes == 32'd0) || !run_ok || (addr < base) ||
                        (off >= {32'd0, bbytes});
  assign stat.div_done = div_done;
  assign stat.slot_bad = (div_r != 32'd0) || (div_q >= {32'd0, count}) ||
                         (div_q > SLOT_MAX);

  // Hash: mix with the slot, fold, then a 64-bit multiply from three partial products.
  assign x0   = handle ^ ({48'd0, div_q[15:0]} + HASH_ADD);
  assign ma   = (cmd.mul_sel == 2'd2) ? x[63:32] : x[31:0];
  assign mb   = (cmd.mul_sel == 2'd1) ? HASH_MUL[63:32] : HASH_MUL[31:0];
  assign prod = {32'd0, ma} * {32'd0, mb};

  always_ff @(posedge clk) begin
    if (cmd.slot_check) begin
      slot <= div_q[15:0];
      x    <= x0 ^ (x0 >> HASH_SHIFT);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_sel == 2'd0) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[31:0], 32'd0};
      end
    end
  end

  // The remainder is built from the top hash bit down, four bits per cycle,
  // each bit by a shift and one compare and subtract of the table size.
  always_comb begin
    red_step = {1'b0, red_rem};
    for (int k = 0; k < 4; k++) begin
      red_step = {red_step[16:0], red_val[63 - k]};
      if (red_step >= MOD_N) red_step = red_step - MOD_N;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      red_busy <= 1'b0;
      red_done <= 1'b0;
      red_cnt  <= '0;
    end else if (cmd.div_mod) begin
      red_busy <= 1'b1;
      red_done <= 1'b0;
      red_cnt  <= '0;
    end else if (red_busy) begin
      red_cnt <= red_cnt + 4'd1;
      if (red_cnt == 4'd15) begin
        red_busy <= 1'b0;
        red_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_mod) begin
      red_val <= hmix;
      red_rem <= '0;
    end else if (red_busy) begin
      red_val <= {red_val[59:0], 4'd0};
      red_rem <= red_step[16:0];
    end
  end

  assign stat.mod_done = red_done;

  // Probe walk.
  logic free, match, differ, do_wr, we;
  logic [IW-1:0] waddr;
  entry_t wdata;

  assign free   = !rd.used;
  assign match  = (rd.blk == handle) && (rd.base == base) && (rd.slot == slot);
  assign differ = (rd.owner != owner) || (rd.gen != gen);
  assign stat.probe_stop = free || match;
  assign stat.probe_last = cnt == LAST_IDX;
  assign stat.clr_last   = clr_idx == LAST_IDX;

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      idx  <= red_rem[IW-1:0];
      cnt  <= '0;
      coll <= '0;
    end else if (cmd.probe_adv) begin
      idx  <= (idx == LAST_IDX) ? '0 : idx + IW'(1);
      cnt  <= cnt + IW'(1);
      coll <= coll + 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_en) begin
      clr_idx <= clr_idx + IW'(1);
    end
  end

  // Table memory; the clearing pass after reset writes every used mark low.
  entry_t mem [TABLE_ENTRIES];

  assign do_wr = cmd.commit && (cmd.res_sel == RES_PROBE) && (op == OP_RECORD) &&
                 (free || (match && differ));
  assign we    = cmd.clr_en || do_wr;
  assign waddr = cmd.clr_en ? clr_idx : idx;
  assign wdata = cmd.clr_en ? '0 : entry_t'{used: 1'b1, blk: handle, base: base,
                                            slot: slot, owner: owner, gen: gen};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rd <= mem[idx];
    end
  end

  // Result and output register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique case (cmd.res_sel)
        RES_PROBE: begin
          res_slot <= slot;
          res_coll <= (op == OP_RECORD) ? coll : 11'd0;
          if (op == OP_RECORD) begin
            res_fb <= 1'b0;
            if (free) begin
              res_outcome <= OUT_INSERTED;
            end else if (differ) begin
              res_outcome <= OUT_HIT_UPDATED;
            end else begin
              res_outcome <= OUT_HIT_MATCH;
            end
          end else if (free) begin
            res_outcome <= OUT_MISS;
            res_fb      <= 1'b1;
          end else if (rd.gen != gen) begin
            res_outcome <= OUT_STALE;
            res_fb      <= 1'b1;
          end else if (rd.owner == owner) begin
            res_outcome <= eq ? OUT_WOULD_SKIP : OUT_FALSE_POS;
            res_fb      <= 1'b0;
          end else begin
            res_outcome <= OUT_MISMATCH;
            res_fb      <= 1'b1;
          end
        end
        RES_FULL: begin
          res_slot    <= slot;
          res_outcome <= (op == OP_RECORD) ? OUT_FULL : OUT_MISS;
          res_fb      <= op;
          res_coll    <= (op == OP_RECORD) ? coll + 11'd1 : 11'd0;
        end
        default: begin
          res_slot    <= '0;
          res_outcome <= OUT_REJECTED;
          res_fb      <= 1'b0;
          res_coll    <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      m_tdata <= {res_slot, res_coll, res_fb, res_outcome};
    end
  end

endmodule

@@ hdl/soht_ctrl.sv @@
// ----------------------------------------------------------------------------
// soht_ctrl: sequencer of the slot owner hash table
// Steps one request through check, divide, hash, reduce, probe and result.
// ----------------------------------------------------------------------------
module soht_ctrl import soht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  output logic  m_tvalid,
  input  logic  m_tready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_PRE   = 11'b000_0000_0100,
    S_DIVS  = 11'b000_0000_1000,
    S_SCHK  = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_MOD   = 11'b000_0100_0000,
    S_DIVM  = 11'b000_1000_0000,
    S_PRD   = 11'b001_0000_0000,
    S_PCMP  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] mul_cnt, mul_cnt_next;
  logic       out_free;

  assign s_tready = state == S_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    mul_cnt_next = mul_cnt;
    cmd          = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (stat.pre_bad) begin
          cmd.commit  = 1'b1;
          cmd.res_sel = RES_REJECT;
          state_next  = S_FIN;
        end else begin
          cmd.div_slot = 1'b1;
          state_next   = S_DIVS;
        end
      end
      S_DIVS: begin
        if (stat.div_done) state_next = S_SCHK;
      end
      S_SCHK: begin
        if (stat.slot_bad) begin
          cmd.commit  = 1'b1;
          cmd.res_sel = RES_REJECT;
          state_next  = S_FIN;
        end else begin
          cmd.slot_check = 1'b1;
          mul_cnt_next   = 2'd0;
          state_next     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mul_cnt;
        mul_cnt_next = mul_cnt + 2'd1;
        if (mul_cnt == 2'd2) state_next = S_MOD;
      end
      S_MOD: begin
        cmd.div_mod = 1'b1;
        state_next  = S_DIVM;
      end
      S_DIVM: begin
        if (stat.mod_done) begin
          cmd.probe_init = 1'b1;
          state_next     = S_PRD;
        end
      end
      S_PRD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        if (stat.probe_stop) begin
          cmd.commit  = 1'b1;
          cmd.res_sel = RES_PROBE;
          state_next  = S_FIN;
        end else if (stat.probe_last) begin
          cmd.commit  = 1'b1;
          cmd.res_sel = RES_FULL;
          state_next  = S_FIN;
        end else begin
          cmd.probe_adv = 1'b1;
          state_next    = S_PRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      mul_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      mul_cnt <= mul_cnt_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/slot_owner_hash_table.sv @@
// ----------------------------------------------------------------------------
// slot_owner_hash_table: owner and generation table with linear probing
// Works out a slot index, hashes it with the block handle and records or
// checks the owner of that slot in an open-addressed table.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Words                     Sideband
//   s_*      in         one request per word      tuser = opcode
//   m_*      out        one result per request    none
//
// After a request is taken, the block runs range checks, a serial divide for the
// slot index, slot checks, 32x32 partial products for the hash, a reduction of
// the hash modulo TABLE_ENTRIES four bits per cycle, one memory read and compare
// per probe, and a load of the output register. A request refused by the range
// checks or by the slot checks skips the remaining steps and goes to the result.
// After reset a clearing pass writes every used mark low; s_tready stays low
// during it. One request is worked at a time and the next one is taken the
// cycle after the result is loaded, even while that result waits in the output
// register; the block stalls only when a second result is ready before the
// first one has been taken.
//
module slot_owner_hash_table import soht_pkg::*; #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // s_tdata from bit 0: block_handle(64) block_base(64) block_bytes(32)
  // object_addr(64) object_bytes(32) slot_count(32) run_ok(1) owner_tag(16)
  // generation(32) owners_equal(1), then zero padding.
  input  logic [IN_W-1:0]  s_tdata,
  // s_tuser: opcode(1).
  input  logic [0:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // m_tdata from bit 0: outcome(4) fallback(1) collisions(11) slot_number(16).
  output logic [OUT_W-1:0] m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the handshakes; the datapath holds all payload.
  soht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  soht_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

  // The clearing pass must hold off requests right after reset.
  assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request accepted during clearing pass");

  // Every delivered outcome is a defined code.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= OUT_MISMATCH))
    else $error("undefined outcome code");

  // Fallback is raised only by miss, stale and mismatch.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |->
      (m_tdata[3:0] == OUT_MISS || m_tdata[3:0] == OUT_STALE ||
       m_tdata[3:0] == OUT_MISMATCH))
    else $error("fallback with wrong outcome");

endmodule
